>>> hw/rtl/lpbp_pkg.sv
// ----------------------------------------------------------------------------
// lpbp_pkg: shared types and constants of the page buffer pool
// Item structs, command codes and controller/datapath link structs.
// ----------------------------------------------------------------------------
`default_nettype none
package lpbp_pkg;

	localparam int unsigned POOL_ENTRIES_DEF  = 64;
	localparam int unsigned TABLE_ID_BITS_DEF = 8;
	localparam int unsigned PAGE_ID_BITS_DEF  = 16;
	localparam int unsigned STAMP_BITS        = 64;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_MARK   = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  table_id;
		logic [15:0] page_id;
		logic [5:0]  entry_index;
	} in_item_t;

	typedef struct packed {
		logic        hit;
		logic [5:0]  slot;
		logic        fill_needed;
		logic        writeback;
		logic [7:0]  wb_table_id;
		logic [15:0] wb_page_id;
		logic        last;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the input item, restart the entry scan
		logic scan_step;  // read one entry, advance the scan pointer
		logic do_lookup;  // apply the lookup result
		logic do_mark;    // apply mark dirty
		logic flush_rd;   // read the lowest valid dirty entry
		logic flush_emit; // emit that entry and clear its dirty bit
		logic emit_none;  // emit the empty flush result
	} lpbp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;  // scan pointer at the last entry
		logic any_dirty;  // some valid entry is dirty
		logic flush_more; // another dirty entry follows the one being emitted
	} lpbp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/lpbp_datapath.sv
// ----------------------------------------------------------------------------
// lpbp_datapath: entry store, scan unit and result former
// Tags and stamps sit in RAMs read one entry a cycle; tag match, free search
// and two LRU minimum searches run as running registers over the scan.
// Valid and dirty flags are registers. Also holds the generic RAM module.
// ----------------------------------------------------------------------------
`default_nettype none
module lpbp_datapath #(
	parameter int unsigned POOL_ENTRIES  = lpbp_pkg::POOL_ENTRIES_DEF,
	parameter int unsigned TABLE_ID_BITS = lpbp_pkg::TABLE_ID_BITS_DEF,
	parameter int unsigned PAGE_ID_BITS  = lpbp_pkg::PAGE_ID_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lpbp_pkg::in_item_t  item,
	input  lpbp_pkg::lpbp_cmd_t ctl,
	output lpbp_pkg::lpbp_stat_t stat,
	output lpbp_pkg::out_item_t result
);
	localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int unsigned SW = lpbp_pkg::STAMP_BITS;
	localparam int unsigned TW = TABLE_ID_BITS + PAGE_ID_BITS;

	logic [POOL_ENTRIES-1:0] valid_q, dirty_q, vd, fidx_hot;
	logic [SW-1:0]            counter_q;

	logic [TABLE_ID_BITS-1:0] ktab_q;
	logic [PAGE_ID_BITS-1:0]  kpg_q;
	logic [5:0]  kidx_q;
	logic [IW-1:0] ptr_q, ptr_s1, fidx_s1;
	logic        chk_s1;
	logic        match_q, free_q, clean_q;
	logic [IW-1:0] match_idx_q, free_idx_q, clean_idx_q, lru_idx_q;
	logic [SW-1:0] clean_min_q, lru_min_q;
	logic [TW-1:0] lru_tag_q;

	logic [TABLE_ID_BITS-1:0] in_tab;
	logic [PAGE_ID_BITS-1:0]  in_pg;
	logic [TW-1:0] key, tag_rd;
	logic [SW-1:0] stamp_rd, next_stamp;
	logic [IW-1:0] victim, sel, mark_idx, rd_addr, stamp_waddr, first_dirty;
	logic          cur_valid, cur_match, cur_clean, first;
	logic          mark_we, stamp_we, tag_we, lookup_wb;
	lpbp_pkg::out_item_t res_d;

	assign in_tab      = TABLE_ID_BITS'(item.table_id);
	assign in_pg       = PAGE_ID_BITS'(item.page_id);
	assign key         = {ktab_q, kpg_q};
	assign cur_valid   = valid_q[ptr_s1];
	assign cur_match   = cur_valid && tag_rd == key;
	assign cur_clean   = !dirty_q[ptr_s1];
	assign first       = (ptr_s1 == '0);
	assign victim      = free_q ? free_idx_q : (clean_q ? clean_idx_q : lru_idx_q);
	assign sel         = match_q ? match_idx_q : victim;
	// with no free and no clean entry the victim is the LRU dirty one
	assign lookup_wb   = !match_q && !free_q && !clean_q;
	assign mark_idx    = IW'(kidx_q);
	assign mark_we     = ctl.do_mark && 32'(kidx_q) < POOL_ENTRIES;
	assign stamp_we    = ctl.do_lookup || mark_we;
	assign stamp_waddr = ctl.do_mark ? mark_idx : sel;
	assign tag_we      = ctl.do_lookup && !match_q;
	assign next_stamp  = counter_q + 1'b1;
	assign vd          = valid_q & dirty_q;
	assign fidx_hot    = {{(POOL_ENTRIES-1){1'b0}}, 1'b1} << fidx_s1;
	assign rd_addr     = ctl.flush_rd ? first_dirty : ptr_q;

	always_comb begin
		first_dirty = '0;
		for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
			if (vd[i]) first_dirty = IW'(i);
		end
	end

	assign stat.scan_done  = (ptr_q == IW'(POOL_ENTRIES - 1));
	assign stat.any_dirty  = |vd;
	assign stat.flush_more = |(vd & ~fidx_hot);

	lpbp_ram #(.WIDTH(TW), .DEPTH(POOL_ENTRIES)) u_tag_ram (
		.clk, .we(tag_we), .waddr(sel), .wdata(key), .raddr(rd_addr), .rdata(tag_rd)
	);

	lpbp_ram #(.WIDTH(SW), .DEPTH(POOL_ENTRIES)) u_stamp_ram (
		.clk, .we(stamp_we), .waddr(stamp_waddr), .wdata(next_stamp), .raddr(rd_addr),
		.rdata(stamp_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			counter_q <= '0;
			ptr_q     <= '0;
			chk_s1    <= 1'b0;
			match_q   <= 1'b0;
			free_q    <= 1'b0;
			clean_q   <= 1'b0;
		end else begin
			chk_s1 <= ctl.scan_step;
			if (ctl.capture) begin
				ptr_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
				clean_q <= 1'b0;
			end
			if (ctl.scan_step && !stat.scan_done) ptr_q <= ptr_q + 1'b1;
			if (chk_s1) begin
				if (cur_match) match_q <= 1'b1;
				if (!cur_valid) free_q <= 1'b1;
				if (cur_clean) clean_q <= 1'b1;
			end
			if (stamp_we) counter_q <= next_stamp;
			if (tag_we) begin
				valid_q[sel] <= 1'b1;
				dirty_q[sel] <= 1'b0;
			end
			if (mark_we) dirty_q[mark_idx] <= 1'b1;
			if (ctl.flush_emit) dirty_q[fidx_s1] <= 1'b0;
		end
	end

	// read data of the entry at ptr_s1 comes from the registered RAM read port, so it arrives in the cycle after its read
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			ktab_q <= in_tab;
			kpg_q  <= in_pg;
			kidx_q <= item.entry_index;
		end
		if (ctl.scan_step) ptr_s1 <= ptr_q;
		if (ctl.flush_rd) fidx_s1 <= first_dirty;
		if (chk_s1) begin
			if (cur_match && !match_q) match_idx_q <= ptr_s1;
			if (!cur_valid && !free_q) free_idx_q <= ptr_s1;
			if (cur_clean && (!clean_q || stamp_rd < clean_min_q)) begin
				clean_min_q <= stamp_rd;
				clean_idx_q <= ptr_s1;
			end
			if (first || stamp_rd < lru_min_q) begin
				lru_min_q <= stamp_rd;
				lru_idx_q <= ptr_s1;
				lru_tag_q <= tag_rd;
			end
		end
		result <= res_d;
	end

	// result former; the register holds while the transfer waits
	always_comb begin
		res_d = result;
		if (ctl.do_lookup) begin
			res_d             = '0;
			res_d.hit         = match_q;
			res_d.slot        = 6'(sel);
			res_d.fill_needed = !match_q;
			if (lookup_wb) begin
				res_d.writeback   = 1'b1;
				res_d.wb_table_id = 8'(lru_tag_q[TW-1:PAGE_ID_BITS]);
				res_d.wb_page_id  = 16'(lru_tag_q[PAGE_ID_BITS-1:0]);
			end
			res_d.last = 1'b1;
		end else if (ctl.do_mark) begin
			res_d      = '0;
			res_d.slot = kidx_q;
			res_d.last = 1'b1;
		end else if (ctl.flush_emit) begin
			res_d             = '0;
			res_d.slot        = 6'(fidx_s1);
			res_d.writeback   = 1'b1;
			res_d.wb_table_id = 8'(tag_rd[TW-1:PAGE_ID_BITS]);
			res_d.wb_page_id  = 16'(tag_rd[PAGE_ID_BITS-1:0]);
			res_d.last        = !stat.flush_more;
		end else if (ctl.emit_none) begin
			res_d      = '0;
			res_d.last = 1'b1;
		end
	end

	flush_pick_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush_emit |-> valid_q[fidx_s1] && dirty_q[fidx_s1])
		else $error("flush emitted an entry that is not valid and dirty");
	counter_steps: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctl.do_lookup) |-> counter_q == $past(counter_q) + 1'b1)
		else $error("access counter did not advance on lookup");
	scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) < POOL_ENTRIES)
		else $error("scan pointer out of range");
endmodule

// generic RAM, one write port, one registered read port
module lpbp_ram #(
	parameter int unsigned WIDTH = lpbp_pkg::STAMP_BITS,
	parameter int unsigned DEPTH = lpbp_pkg::POOL_ENTRIES_DEF
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> hw/rtl/lpbp_ctrl.sv
// ----------------------------------------------------------------------------
// lpbp_ctrl: command sequencer of the page buffer pool
// Drives the entry scan and result transfers; holds the output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module lpbp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire [1:0]            in_cmd,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  lpbp_pkg::lpbp_stat_t stat,
	output lpbp_pkg::lpbp_cmd_t  ctl
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_END, ST_APPLY, ST_FLUSH_RD, ST_FLUSH_EMIT,
		ST_FLUSH_WAIT, ST_OUT
	} state_t;

	state_t   state_q;
	logic [1:0] cmd_q;
	logic     in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		ctl = '0;
		ctl.capture    = in_fire;
		ctl.scan_step  = (state_q == ST_SCAN);
		ctl.do_lookup  = (state_q == ST_APPLY) && cmd_q == lpbp_pkg::CMD_LOOKUP;
		ctl.do_mark    = (state_q == ST_APPLY) && cmd_q == lpbp_pkg::CMD_MARK;
		ctl.flush_rd   = (state_q == ST_FLUSH_RD) && stat.any_dirty;
		ctl.emit_none  = (state_q == ST_FLUSH_RD) && !stat.any_dirty;
		ctl.flush_emit = (state_q == ST_FLUSH_EMIT);
	end

	// a flushed entry waits for its transfer before the next one is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= lpbp_pkg::CMD_LOOKUP;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q <= in_cmd;
						case (in_cmd)
							lpbp_pkg::CMD_LOOKUP: state_q <= ST_SCAN;
							lpbp_pkg::CMD_MARK:   state_q <= ST_APPLY;
							lpbp_pkg::CMD_FLUSH:  state_q <= ST_FLUSH_RD;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					if (stat.scan_done) state_q <= ST_SCAN_END;
				end
				ST_SCAN_END: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					out_valid <= 1'b1;
					state_q   <= ST_OUT;
				end
				ST_FLUSH_RD: begin
					if (stat.any_dirty) begin
						state_q <= ST_FLUSH_EMIT;
					end else begin
						out_valid <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_FLUSH_EMIT: begin
					out_valid <= 1'b1;
					state_q   <= stat.flush_more ? ST_FLUSH_WAIT : ST_OUT;
				end
				ST_FLUSH_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_FLUSH_RD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !out_valid)
		else $error("result pending while idle");
	wait_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH_WAIT || state_q == ST_OUT) |-> out_valid)
		else $error("transfer wait without a result");
	no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input accepted while a result waits");
	result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");
endmodule
`default_nettype wire

>>> hw/rtl/lru_page_buffer_pool_unit.sv
// ----------------------------------------------------------------------------
// lru_page_buffer_pool_unit: LRU page buffer pool, clean-first eviction
//
//   channel | dir | handshake            | payload
//   in      | in  | in_valid / in_ready  | in_item  (lpbp_pkg::in_item_t)
//   out     | out | out_valid / out_ready| out_item (lpbp_pkg::out_item_t)
//
// Lookup: the scan reads one entry a cycle, plus a registered RAM read, then
// the result is applied. Mark dirty applies at once. Flush reports each
// valid dirty entry in its own transfer, or one empty result if none.
// Reset clears valid and dirty flags and the counter; RAMs need no clearing.
// A stalled output holds the item; one item is in work at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_page_buffer_pool_unit #(
	parameter int unsigned POOL_ENTRIES  = lpbp_pkg::POOL_ENTRIES_DEF,
	parameter int unsigned TABLE_ID_BITS = lpbp_pkg::TABLE_ID_BITS_DEF,
	parameter int unsigned PAGE_ID_BITS  = lpbp_pkg::PAGE_ID_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  lpbp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  wire                 out_ready,
	output lpbp_pkg::out_item_t out_item
);
	lpbp_pkg::lpbp_cmd_t  ctl;
	lpbp_pkg::lpbp_stat_t stat;

	lpbp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_cmd(in_item.cmd),
		.out_valid, .out_ready, .stat, .ctl
	);

	lpbp_datapath #(
		.POOL_ENTRIES(POOL_ENTRIES), .TABLE_ID_BITS(TABLE_ID_BITS),
		.PAGE_ID_BITS(PAGE_ID_BITS)
	) u_dp (
		.clk, .arst_n, .item(in_item), .ctl, .stat, .result(out_item)
	);
endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lru_page_buffer_pool_unit
// Drives lookups, mark-dirty and flush commands with random idle cycles on
// both channels, predicts every result from a behavioral copy of the pool
// and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NENT = 64;
	localparam int MAX_FLUSH = 64;
	localparam logic [1:0] CMD_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lpbp_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	lpbp_pkg::out_item_t out_item;

	lru_page_buffer_pool_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	// pool shadow
	bit pool_valid [NENT];
	bit [7:0] pool_table [NENT];
	bit [15:0] pool_page [NENT];
	bit pool_dirty [NENT];
	bit [63:0] pool_stamp [NENT];
	bit [63:0] access_count;

	lpbp_pkg::out_item_t pending_results[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int hits = 0;
	int evictions = 0;
	int flushed = 0;
	bit idle_on = 1;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic lpbp_pkg::out_item_t make_result(bit h, bit [5:0] s, bit f, bit w,
			bit [7:0] t, bit [15:0] p, bit l);
		lpbp_pkg::out_item_t r;
		r.hit = h; r.slot = s; r.fill_needed = f; r.writeback = w;
		r.wb_table_id = t; r.wb_page_id = p; r.last = l;
		return r;
	endfunction

	function automatic int pick_victim();
		int best;
		best = -1;
		for (int i = 0; i < NENT; i++)
			if (!pool_valid[i]) return i;
		for (int i = 0; i < NENT; i++)
			if (!pool_dirty[i] && (best < 0 || pool_stamp[i] < pool_stamp[best]))
				best = i;
		if (best >= 0) return best;
		best = 0;
		for (int i = 1; i < NENT; i++)
			if (pool_stamp[i] < pool_stamp[best]) best = i;
		return best;
	endfunction

	task automatic predict_pool(lpbp_pkg::in_item_t it);
		int v;
		int n;
		bit wb;
		lpbp_pkg::out_item_t r;
		case (it.cmd)
			lpbp_pkg::CMD_LOOKUP: begin
				for (int i = 0; i < NENT; i++) begin
					if (pool_valid[i] && pool_table[i] == it.table_id &&
							pool_page[i] == it.page_id) begin
						access_count++;
						pool_stamp[i] = access_count;
						pending_results.push_back(make_result(1'b1, 6'(i), 1'b0, 1'b0,
							8'd0, 16'd0, 1'b1));
						hits++;
						return;
					end
				end
				v = pick_victim();
				wb = pool_valid[v] && pool_dirty[v];
				if (wb) evictions++;
				pending_results.push_back(make_result(1'b0, 6'(v), 1'b1, wb,
					wb ? pool_table[v] : 8'd0, wb ? pool_page[v] : 16'd0, 1'b1));
				pool_valid[v] = 1;
				pool_table[v] = it.table_id;
				pool_page[v] = it.page_id;
				pool_dirty[v] = 0;
				access_count++;
				pool_stamp[v] = access_count;
			end
			lpbp_pkg::CMD_MARK: begin
				pool_dirty[it.entry_index] = 1;
				access_count++;
				pool_stamp[it.entry_index] = access_count;
				pending_results.push_back(make_result(1'b0, it.entry_index, 1'b0, 1'b0,
					8'd0, 16'd0, 1'b1));
			end
			lpbp_pkg::CMD_FLUSH: begin
				n = 0;
				for (int i = 0; i < NENT && n < MAX_FLUSH; i++) begin
					if (pool_valid[i] && pool_dirty[i]) begin
						pool_dirty[i] = 0;
						pending_results.push_back(make_result(1'b0, 6'(i), 1'b0, 1'b1,
							pool_table[i], pool_page[i], 1'b0));
						n++;
					end
				end
				if (n == 0) pending_results.push_back(make_result(1'b0, 6'd0, 1'b0, 1'b0,
					8'd0, 16'd0, 1'b1));
				else begin
					r = pending_results.pop_back();
					r.last = 1;
					pending_results.push_back(r);
				end
				flushed += n;
			end
			default: ;
		endcase
	endtask

	// in_valid stays high into the next item unless an idle gap is drawn
	task automatic send_item(logic [1:0] c, logic [7:0] t, logic [15:0] p,
			logic [5:0] e);
		lpbp_pkg::in_item_t it;
		bit waited;
		it.cmd = c; it.table_id = t; it.page_id = p; it.entry_index = e;
		waited = 0;
		while (idle_on && $urandom_range(99) < 34) begin
			if (!waited) in_valid <= 1'b0;
			waited = 1;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_pool(it);
		sent++;
	endtask

	// output side: random back-pressure and checking
	always @(posedge clk) begin
		lpbp_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				received++;
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer slot=%0d", out_item.slot);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (out_item.hit !== want.hit) begin
						$error("hit exp %0d got %0d", want.hit, out_item.hit); errors++;
					end
					if (out_item.slot !== want.slot) begin
						$error("slot exp %0d got %0d", want.slot, out_item.slot); errors++;
					end
					if (out_item.fill_needed !== want.fill_needed) begin
						$error("fill_needed exp %0d got %0d", want.fill_needed,
							out_item.fill_needed); errors++;
					end
					if (out_item.writeback !== want.writeback) begin
						$error("writeback exp %0d got %0d", want.writeback,
							out_item.writeback); errors++;
					end
					if (out_item.wb_table_id !== want.wb_table_id) begin
						$error("wb_table_id exp %0h got %0h", want.wb_table_id,
							out_item.wb_table_id); errors++;
					end
					if (out_item.wb_page_id !== want.wb_page_id) begin
						$error("wb_page_id exp %0h got %0h", want.wb_page_id,
							out_item.wb_page_id); errors++;
					end
					if (out_item.last !== want.last) begin
						$error("last exp %0d got %0d", want.last, out_item.last); errors++;
					end
				end
			end
			out_ready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
		end
	end

	task automatic test_directed();
		send_item(lpbp_pkg::CMD_FLUSH, 8'd0, 16'd0, 6'd0);          // empty flush
		send_item(lpbp_pkg::CMD_LOOKUP, 8'h00, 16'h0000, 6'd0);
		send_item(lpbp_pkg::CMD_LOOKUP, 8'hFF, 16'hFFFF, 6'd0);
		send_item(lpbp_pkg::CMD_LOOKUP, 8'h00, 16'h0000, 6'd0); // hit
		send_item(lpbp_pkg::CMD_MARK, 8'd0, 16'd0, 6'd0);
		send_item(lpbp_pkg::CMD_MARK, 8'd0, 16'd0, 6'd63);        // mark on a free entry
		send_item(CMD_NONE, 8'hA5, 16'h5A5A, 6'd21); // no result
		send_item(lpbp_pkg::CMD_LOOKUP, 8'hFF, 16'hFFFF, 6'd0);
		send_item(lpbp_pkg::CMD_FLUSH, 8'd0, 16'd0, 6'd0);
		send_item(lpbp_pkg::CMD_FLUSH, 8'd0, 16'd0, 6'd0);
	endtask

	// fill the pool, then make clean and dirty eviction both happen
	task automatic test_eviction();
		for (int i = 0; i < 62; i++) send_item(lpbp_pkg::CMD_LOOKUP, 8'h10, 16'(i), 6'd0);
		send_item(lpbp_pkg::CMD_LOOKUP, 8'h20, 16'h0001, 6'd0); // clean LRU victim
		for (int i = 0; i < NENT; i++) send_item(lpbp_pkg::CMD_MARK, 8'd0, 16'd0, 6'(i));
		send_item(lpbp_pkg::CMD_LOOKUP, 8'h30, 16'h0002, 6'd0); // dirty LRU victim
		send_item(lpbp_pkg::CMD_LOOKUP, 8'h30, 16'h0003, 6'd0);
		send_item(lpbp_pkg::CMD_FLUSH, 8'd0, 16'd0, 6'd0);           // long flush
	endtask

	task automatic test_random(int count);
		logic [1:0] c;
		for (int n = 0; n < count; n++) begin
			idle_on = !(n >= count / 3 && n < count / 2);
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: c = lpbp_pkg::CMD_LOOKUP;
				11, 12, 13, 14, 15, 16: c = lpbp_pkg::CMD_MARK;
				17, 18: c = lpbp_pkg::CMD_FLUSH;
				default: c = CMD_NONE;
			endcase
			// narrow tag space gives hits; occasionally the full range
			if ($urandom_range(3) == 0)
				send_item(c, 8'($urandom), 16'($urandom), 6'($urandom));
			else
				send_item(c, 8'($urandom_range(3)), 16'($urandom_range(40)),
					6'($urandom));
		end
		idle_on = 1;
	endtask

	initial begin
		int guard;
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_ready = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_eviction();
		test_random(200);
		in_valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		$display("Sent %0d commands, checked %0d results (%0d hits, %0d dirty evictions,",
			sent, received, hits, evictions);
		$display("  %0d flushed entries)", flushed);
		if (errors == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
